// ===== src/itg_pkg.sv =====
// ----------------------------------------------------------------------------
// itg_pkg: shared types and constants for the grouped integer text formatter
// Character codes, sizing constants and the controller/datapath interface.
// ----------------------------------------------------------------------------
package itg_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_CHARS      = 33;   // longest text emitted per number
  localparam int ADDR_W         = $clog2(MAX_CHARS + 1);
  localparam int BITS_PER_CYC   = 8;    // long-division bits retired per cycle

  localparam logic [7:0] POINT_CHAR = 8'h2E;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [5:0] RADIX_DEF  = 6'd10;
  localparam logic [5:0] RADIX_MIN  = 6'd2;
  localparam logic [5:0] RADIX_MAX  = 6'd36;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture a new transaction
    logic div_step;   // one chunk of long division
    logic put_digit;  // store current digit, decide on point/separator
    logic put_extra;  // store the pending point/separator
    logic put_sign;   // store minus sign if negative, arm readout
    logic rd;         // read character buffer
    logic rd_next;    // step readout address toward the last character
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;   // this division chunk is the final one
    logic extra_now;  // digit being stored needs a point or separator after it
    logic q_zero;     // quotient is zero: no more digits
    logic addr_zero;  // readout is at the final character
  } dp_stat_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? 8'h41 : 8'h61;
    if (d < 6'd10) begin
      digit_char = 8'h30 + {2'b00, d};
    end else begin
      digit_char = base + {2'b00, d} - 8'd10;
    end
  endfunction

endpackage

// ===== src/itg_in_if.sv =====
// ----------------------------------------------------------------------------
// itg_in_if: input channel of the grouped integer text formatter
// Valid/ready channel carrying one number and its formatting options.
// ----------------------------------------------------------------------------
interface itg_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [5:0]            radix;
  logic                  upper_case;
  logic [3:0]            group_size;
  logic [7:0]            separator;
  logic [4:0]            decimal_places;

  modport source (
    output valid, value, radix, upper_case, group_size, separator, decimal_places,
    input  ready
  );
  modport sink (
    input  valid, value, radix, upper_case, group_size, separator, decimal_places,
    output ready
  );
endinterface

// ===== src/itg_out_if.sv =====
// ----------------------------------------------------------------------------
// itg_out_if: character channel of the grouped integer text formatter
// Valid/ready channel carrying one text character and its end marker.
// ----------------------------------------------------------------------------
interface itg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;

  modport source (
    output valid, text_char, last_char,
    input  ready
  );
  modport sink (
    input  valid, text_char, last_char,
    output ready
  );
endinterface

// ===== src/itg_dp.sv =====
// ----------------------------------------------------------------------------
// itg_dp: datapath of the grouped integer text formatter
// Chunked long division by the radix, character assembly into a buffer,
// and buffer readout in reverse order.
// ----------------------------------------------------------------------------
module itg_dp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  itg_pkg::dp_cmd_t      cmd,
  output itg_pkg::dp_stat_t     stat,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [5:0]            radix,
  input  logic                  upper_case,
  input  logic [3:0]            group_size,
  input  logic [7:0]            separator,
  input  logic [4:0]            decimal_places,
  output logic [7:0]            text_char,
  output logic                  last_char
);
  import itg_pkg::*;

  localparam int CHUNKS  = (VALUE_BITS + BITS_PER_CYC - 1) / BITS_PER_CYC;
  localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int WORK_W  = CHUNKS * BITS_PER_CYC;
  localparam int IDX_W   = $clog2(VALUE_BITS + 1);
  localparam int CMP_W   = ((IDX_W > 5) ? IDX_W : 5) + 1;

  // operand/options captured at load
  logic [WORK_W-1:0]  work_r;      // dividend, then quotient
  logic [5:0]         rem_r;
  logic [5:0]         radix_r;
  logic               upper_r;
  logic [3:0]         group_r;
  logic [7:0]         sep_r;
  logic [4:0]         places_r;
  logic               neg_r;
  // per-digit bookkeeping
  logic [CHUNK_W-1:0] chunk_r;
  logic [IDX_W-1:0]   idx_r;
  logic               point_done_r;
  logic [3:0]         gcount_r;
  logic [7:0]         extra_char_r;
  logic [ADDR_W-1:0]  len_r;
  logic [ADDR_W-1:0]  rd_addr_r;
  logic [7:0]         rd_data_r;

  logic [7:0]         char_mem [MAX_CHARS];

  logic [VALUE_BITS-1:0] mag;
  logic [WORK_W-1:0]     work_nxt;
  logic [5:0]            rem_nxt;
  logic                  pt_now;
  logic                  sep_now;
  logic [3:0]            gc_inc;
  logic                  wr_en;
  logic [7:0]            wr_data;
  logic                  sign_wr;
  logic [ADDR_W-1:0]     len_fin;

  assign mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

  // restoring long division, BITS_PER_CYC quotient bits per cycle
  always_comb begin
    logic [6:0]        t;
    logic [5:0]        r;
    logic [WORK_W-1:0] w;
    r = rem_r;
    w = work_r;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      t = {r, w[WORK_W-1]};
      w = w << 1;
      if (t >= {1'b0, radix_r}) begin
        t    = t - {1'b0, radix_r};
        w[0] = 1'b1;
      end
      r = t[5:0];
    end
    work_nxt = w;
    rem_nxt  = r;
  end

  assign gc_inc  = gcount_r + 4'd1;
  assign pt_now  = !point_done_r &&
                   ((CMP_W'(idx_r) + CMP_W'(1)) == CMP_W'(places_r));
  assign sep_now = point_done_r && (group_r != 4'd0) && (gc_inc == group_r) &&
                   (work_r != '0);

  assign stat.div_last  = (chunk_r == CHUNK_W'(CHUNKS - 1));
  assign stat.extra_now = pt_now || sep_now;
  assign stat.q_zero    = (work_r == '0);
  assign stat.addr_zero = (rd_addr_r == '0);

  assign sign_wr = cmd.put_sign && neg_r;
  assign wr_en   = (cmd.put_digit || cmd.put_extra || sign_wr) &&
                   (len_r < ADDR_W'(MAX_CHARS));
  always_comb begin
    if (cmd.put_digit) begin
      wr_data = digit_char(rem_r, upper_r);
    end else if (cmd.put_extra) begin
      wr_data = extra_char_r;
    end else begin
      wr_data = MINUS_CHAR;
    end
  end
  assign len_fin = (sign_wr && (len_r < ADDR_W'(MAX_CHARS))) ? len_r + 1'b1 : len_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      char_mem[len_r] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= char_mem[rd_addr_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r   <= WORK_W'(mag);
      rem_r    <= '0;
      radix_r  <= (radix inside {[RADIX_MIN:RADIX_MAX]}) ? radix : RADIX_DEF;
      upper_r  <= upper_case;
      group_r  <= group_size;
      sep_r    <= separator;
      places_r <= decimal_places;
      neg_r    <= value[VALUE_BITS-1];
    end else if (cmd.div_step) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end else if (cmd.put_digit) begin
      rem_r        <= '0;
      extra_char_r <= pt_now ? POINT_CHAR : sep_r;
    end
    if (cmd.put_sign) begin
      rd_addr_r <= len_fin - 1'b1;
    end else if (cmd.rd_next) begin
      rd_addr_r <= rd_addr_r - 1'b1;
    end
  end

  // digit bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r      <= '0;
      idx_r        <= '0;
      point_done_r <= 1'b0;
      gcount_r     <= '0;
      len_r        <= '0;
    end else begin
      if (cmd.load) begin
        chunk_r      <= '0;
        idx_r        <= '0;
        point_done_r <= (decimal_places == 5'd0);
        gcount_r     <= '0;
        len_r        <= '0;
      end else begin
        if (cmd.div_step) begin
          chunk_r <= stat.div_last ? '0 : chunk_r + 1'b1;
        end
        if (cmd.put_digit) begin
          idx_r <= idx_r + 1'b1;
          if (!point_done_r) begin
            if (pt_now) begin
              point_done_r <= 1'b1;
              gcount_r     <= '0;
            end
          end else if (group_r != 4'd0) begin
            gcount_r <= sep_now ? 4'd0 : gc_inc;
          end
        end
        if (cmd.put_sign) begin
          len_r <= len_fin;
        end else if (wr_en) begin
          len_r <= len_r + 1'b1;
        end
      end
    end
  end

  assign text_char = rd_data_r;
  assign last_char = stat.addr_zero;

endmodule

// ===== src/itg_ctrl.sv =====
// ----------------------------------------------------------------------------
// itg_ctrl: sequencer of the grouped integer text formatter
// Steps division, character assembly and readout; owns both handshakes.
// ----------------------------------------------------------------------------
module itg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  itg_pkg::dp_stat_t stat,
  output itg_pkg::dp_cmd_t  cmd
);
  import itg_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_DIGIT = 3'd2;
  localparam logic [2:0] S_EXTRA = 3'd3;
  localparam logic [2:0] S_SIGN  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.put_digit = 1'b1;
        if (stat.extra_now) begin
          state_nxt = S_EXTRA;
        end else if (stat.q_zero) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_EXTRA: begin
        cmd.put_extra = 1'b1;
        state_nxt     = stat.q_zero ? S_SIGN : S_DIV;
      end
      S_SIGN: begin
        cmd.put_sign = 1'b1;
        state_nxt    = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.addr_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/integer_to_grouped_text_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_grouped_text_core: signed integer to radix text with grouping
// Formats a number in radix 2..36 with optional digit groups, an implied
// decimal point and a leading minus sign; one character per transaction.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+---------------------------------------------
//  in_if    | in  | valid/ready | value, radix, upper_case, group_size,
//           |     |             | separator, decimal_places
//  out_if   | out | valid/ready | text_char, last_char (set on final char)
//
//  Sequence: each digit comes from chunked long division (8 quotient bits
//  a cycle) and is stored; points and separators are stored after their
//  digits and the sign after the last digit. At most 33 characters are
//  emitted per number, each as one buffer read followed by an output state.
//  Reset: synchronous active-low rst_n returns the sequencer to idle.
//  Stalls: in_ready is high only while idle; out_if holds a character steady
//  until the sink takes it.
//
module integer_to_grouped_text_core #(
  parameter int VALUE_BITS = itg_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  itg_in_if.sink    in_if,
  itg_out_if.source out_if
);
  import itg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: walks through division chunks per digit, inserts point or
  // separator characters when the datapath flags them, appends the sign,
  // then reads the buffer back from the most significant end.
  itg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: digits are produced least significant first and written into
  // the character buffer in that order; only the first 33 characters are
  // kept, which are the rightmost of the text. Readout runs backwards.
  itg_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .value          (in_if.value),
    .radix          (in_if.radix),
    .upper_case     (in_if.upper_case),
    .group_size     (in_if.group_size),
    .separator      (in_if.separator),
    .decimal_places (in_if.decimal_places),
    .text_char      (out_if.text_char),
    .last_char      (out_if.last_char)
  );

endmodule

// ===== verif/itg_text_checker.sv =====
// ----------------------------------------------------------------------------
// itg_text_checker: scoreboard for the grouped integer text formatter
// Watches both channels. For every accepted number it builds the expected
// characters in order, then compares each accepted output character with them.
// ----------------------------------------------------------------------------
module itg_text_checker (
  input  logic clk,
  input  logic rst_n,
  itg_in_if    in_ch,
  itg_out_if   out_ch,
  output int   error_count,
  output int   chars_pending,
  output int   numbers_taken,
  output int   chars_checked
);
  import itg_pkg::*;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } text_char_t;

  text_char_t pending_text[$];
  text_char_t want;

  // Builds the text right to left, then queues its rightmost MAX_CHARS
  // characters most significant first.
  function automatic void predict_text(input logic [31:0] value,
                                       input logic [5:0]  radix,
                                       input logic        upper,
                                       input logic [3:0]  group,
                                       input logic [7:0]  sep,
                                       input logic [4:0]  places);
    logic [31:0] mag;
    logic [31:0] base;
    logic        neg;
    logic [7:0]  digits [0:31];
    logic [7:0]  rev [0:79];
    logic        point_done;
    int          ndig;
    int          len;
    int          gcount;
    int          n;
    int          i;
    text_char_t  ch;

    neg  = value[31];
    mag  = neg ? (~value + 32'd1) : value;
    base = (radix < RADIX_MIN || radix > RADIX_MAX) ? 32'(RADIX_DEF) : 32'(radix);

    ndig = 0;
    do begin
      digits[ndig] = 8'(mag % base);
      mag = mag / base;
      ndig++;
    end while (mag != 0);

    len = 0;
    gcount = 0;
    point_done = (places == 5'd0);
    for (i = 0; i < ndig; i++) begin
      rev[len] = (digits[i] < 8'd10) ? 8'h30 + digits[i]
                                      : (upper ? 8'h41 : 8'h61) + digits[i] - 8'd10;
      len++;
      if (!point_done) begin
        if (i + 1 == int'(places)) begin
          rev[len] = POINT_CHAR;
          len++;
          point_done = 1'b1;
          gcount = 0;
        end
      end else if (group != 4'd0) begin
        gcount++;
        // no separator after the leading digit, so none next to the sign
        if (gcount == int'(group) && i + 1 < ndig) begin
          rev[len] = sep;
          len++;
          gcount = 0;
        end
      end
    end
    if (neg) begin
      rev[len] = MINUS_CHAR;
      len++;
    end

    n = (len < MAX_CHARS) ? len : MAX_CHARS;
    for (i = 0; i < n; i++) begin
      ch.text_char = rev[n - 1 - i];
      ch.last_char = (i + 1 == n);
      pending_text.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_text(in_ch.value, in_ch.radix, in_ch.upper_case, in_ch.group_size,
                     in_ch.separator, in_ch.decimal_places);
        numbers_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_text.size() == 0) begin
          error_count++;
          $display("%0t: unexpected character: expected none, got %h last %b",
                   $time, out_ch.text_char, out_ch.last_char);
        end else begin
          want = pending_text.pop_front();
          if (out_ch.text_char !== want.text_char) begin
            error_count++;
            $display("%0t: text_char mismatch at character %0d: expected %h, got %h",
                     $time, chars_checked, want.text_char, out_ch.text_char);
          end
          if (out_ch.last_char !== want.last_char) begin
            error_count++;
            $display("%0t: last_char mismatch at character %0d: expected %b, got %b",
                     $time, chars_checked, want.last_char, out_ch.last_char);
          end
          chars_checked++;
        end
      end
      chars_pending = pending_text.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for integer_to_grouped_text_core
// Drives corner-case numbers and then random ones through the input channel
// under three pacing phases; the checker predicts and compares every char.
// ----------------------------------------------------------------------------
module testbench;
  import itg_pkg::*;

  localparam logic [7:0] COMMA      = 8'h2C;
  localparam logic [7:0] UNDERSCORE = 8'h5F;
  localparam logic [7:0] SPACE      = 8'h20;
  localparam int RANDOM_PER_PHASE   = 32;
  localparam int SETTLE_CYCLES      = 300;

  logic clk = 1'b0;
  logic rst_n;

  // percent of cycles each side holds off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int error_count;
  int chars_pending;
  int numbers_taken;
  int chars_checked;

  itg_in_if #(.VALUE_BITS(VALUE_BITS_DEF)) in_ch ();
  itg_out_if out_ch ();

  integer_to_grouped_text_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  itg_text_checker text_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .error_count   (error_count),
    .chars_pending (chars_pending),
    .numbers_taken (numbers_taken),
    .chars_checked (chars_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: reports failure and stops if the whole run has not finished.
  initial begin
    #5000000;
    $display("testbench failed");
    $finish;
  end

  // Receiver: ready re-rolled every falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one number. Entered and left at a falling edge; valid stays high on
  // exit so back-to-back transactions need no extra low cycle.
  task automatic send_number(input logic [31:0] value, input logic [5:0] radix,
                             input logic upper, input logic [3:0] group,
                             input logic [7:0] sep, input logic [4:0] places);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.value          <= value;
    in_ch.radix          <= radix;
    in_ch.upper_case     <= upper;
    in_ch.group_size     <= group;
    in_ch.separator      <= sep;
    in_ch.decimal_places <= places;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted character has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (chars_pending != 0) @(negedge clk);
  endtask

  // Random number, biased toward short readable texts with points and groups,
  // with a share of full-range values, odd radixes and arbitrary separators.
  task automatic send_random_number();
    logic [31:0] value;
    logic [5:0]  radix;
    logic [3:0]  group;
    logic [4:0]  places;
    logic [7:0]  sep;
    int          pick;

    pick = $urandom_range(9);
    if (pick < 4) begin
      value = $urandom;
    end else if (pick < 7) begin
      value = $urandom_range(99999);
      if ($urandom_range(1) == 1) value = -value;
    end else if (pick == 7) begin
      case ($urandom_range(4))
        0:       value = 32'h0000_0000;
        1:       value = 32'h0000_0001;
        2:       value = 32'hFFFF_FFFF;
        3:       value = 32'h7FFF_FFFF;
        default: value = 32'h8000_0000;
      endcase
    end else begin
      value = $urandom >> $urandom_range(31);
      if ($urandom_range(1) == 1) value = -value;
    end

    pick = $urandom_range(9);
    if (pick < 6)       radix = 6'($urandom_range(2, 36));
    else if (pick < 8)  radix = RADIX_DEF;
    else if (pick == 8) radix = 6'd16;
    else                radix = 6'($urandom_range(63));

    group = ($urandom_range(1) == 1) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(15));

    pick = $urandom_range(9);
    if (pick < 5)      places = 5'd0;
    else if (pick < 8) places = 5'($urandom_range(1, 6));
    else               places = 5'($urandom_range(31));

    sep = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : COMMA;

    send_number(value, radix, 1'($urandom_range(1)), group, sep, places);
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.value          = '0;
    in_ch.radix          = '0;
    in_ch.upper_case     = 1'b0;
    in_ch.group_size     = '0;
    in_ch.separator      = '0;
    in_ch.decimal_places = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase 1: sender idles a third of the time, receiver two thirds.
    send_idle_pct = 32;
    recv_idle_pct = 67;

    // --- directed corners ---
    // zero, plain extremes
    send_number(32'h0000_0000, RADIX_DEF, 1'b0, 4'd0, COMMA, 5'd0);
    send_number(32'h7FFF_FFFF, RADIX_DEF, 1'b0, 4'd0, COMMA, 5'd0);
    // most negative value, grouped; no separator may follow the sign
    send_number(32'h8000_0000, RADIX_DEF, 1'b0, 4'd3, COMMA, 5'd0);
    send_number(-32'sd123456,  RADIX_DEF, 1'b0, 4'd3, COMMA, 5'd0);
    // upper-case hex letters, base 36 in both cases with its top digit
    send_number(32'hFFFF_FFFF, 6'd16, 1'b1, 4'd0, COMMA, 5'd0);
    send_number(32'h7FFF_FFFF, 6'd16, 1'b1, 4'd2, SPACE, 5'd0);
    send_number(32'h7FFF_FFFF, RADIX_MAX, 1'b0, 4'd0, COMMA, 5'd0);
    send_number(32'h0000_0023, RADIX_MAX, 1'b1, 4'd0, COMMA, 5'd0);
    // out-of-range radix falls back to decimal
    send_number(32'd987654, 6'd0,  1'b0, 4'd0, COMMA, 5'd0);
    send_number(32'd987654, 6'd1,  1'b1, 4'd0, COMMA, 5'd0);
    send_number(32'd987654, 6'd37, 1'b0, 4'd0, COMMA, 5'd0);
    send_number(32'd987654, 6'd63, 1'b1, 4'd0, COMMA, 5'd0);
    // too long: binary with separators overflows 33 characters
    send_number(32'h7FFF_FFFF, RADIX_MIN, 1'b0, 4'd4, UNDERSCORE, 5'd0);
    send_number(32'h8000_0000, RADIX_MIN, 1'b0, 4'd1, 8'h00, 5'd0);
    // point with exactly enough digits, plain and negative, and on zero
    send_number(32'd12345,     RADIX_DEF, 1'b0, 4'd2, COMMA, 5'd5);
    send_number(-32'sd12345,   RADIX_DEF, 1'b0, 4'd2, COMMA, 5'd5);
    send_number(32'h0000_0000, RADIX_DEF, 1'b0, 4'd0, COMMA, 5'd1);
    // too few digits: no point and no grouping
    send_number(32'd123, RADIX_DEF, 1'b0, 4'd1, COMMA, 5'd5);
    // grouping restarts left of the point
    send_number(32'd123456789, RADIX_DEF, 1'b0, 4'd3, COMMA, 5'd2);
    send_number(-32'sd123456789, RADIX_DEF, 1'b1, 4'd15, 8'hFF, 5'd1);
    // widest point position
    send_number(32'h7FFF_FFFF, RADIX_MIN, 1'b0, 4'd15, COMMA, 5'd31);
    send_number(32'h8000_0000, RADIX_MIN, 1'b0, 4'd15, COMMA, 5'd31);
    send_number(32'hFFFF_FFFF, RADIX_MIN, 1'b0, 4'd0, COMMA, 5'd31);

    repeat (RANDOM_PER_PHASE) send_random_number();
    // sender holds back until the block has emptied
    wait_drained();

    // Phase 2: pacing swapped.
    send_idle_pct = 67;
    recv_idle_pct = 32;
    repeat (RANDOM_PER_PHASE) send_random_number();
    wait_drained();

    // Phase 3: both sides at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_random_number();
    in_ch.valid <= 1'b0;

    // Drain, then give any stray character time to show up.
    while (chars_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d numbers (directed corners, then random in three pacing phases);",
             numbers_taken);
    $display("%0d characters compared, %0d mismatches.", chars_checked, error_count);
    if (error_count == 0 && chars_pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/itg_pkg.sv
src/itg_in_if.sv
src/itg_out_if.sv
src/itg_dp.sv
src/itg_ctrl.sv
src/integer_to_grouped_text_core.sv
verif/itg_text_checker.sv
verif/testbench.sv
